// ===== rtl/ksel_pkg.sv =====
`default_nettype none

package ksel_pkg;

  localparam int HASH_W     = 64;
  localparam int BYTE_W     = 8;
  localparam int MODE_W     = 2;
  localparam int CNT_W      = 11;
  localparam int OFF_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int STEP_W     = $clog2(HASH_W);

  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
  localparam logic [BYTE_W-1:0] SEPARATOR = 8'h1F;

  localparam logic [CNT_W-1:0] WORKER_TOTAL_RST = 11'd1;
  localparam logic [CNT_W-1:0] BCAST_WORKERS_RST = 11'd0;
  localparam logic [CNT_W-1:0] SHARD_WORKERS_RST = 11'd1;
  localparam logic [OFF_W-1:0] SHARD_OFFSET_RST  = 10'd0;

  typedef enum logic [MODE_W-1:0] {
    MODE_FEED_BYTE = 2'd0,
    MODE_FEED_END  = 2'd1,
    MODE_SYM_BYTE  = 2'd2,
    MODE_KEY_END   = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WORKER_TOTAL  = 2'd0,
    CFG_BCAST_WORKERS = 2'd1,
    CFG_SHARD_WORKERS = 2'd2,
    CFG_SHARD_OFFSET  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DIV  = 1'b1
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0] worker_total;
    logic [CNT_W-1:0] bcast_workers;
    logic [CNT_W-1:0] shard_workers;
    logic [OFF_W-1:0] shard_offset;
  } cfg_t;

  typedef struct packed {
    logic mix;
    logic sep;
    logic key_end;
    logic div_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bypass;
    logic div_last;
    logic out_valid;
  } ctrl_sts_t;

  // h * 0x100000001B3 as shift-add: 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 1
  function automatic logic [HASH_W-1:0] fnv_mix(input logic [HASH_W-1:0] h,
                                                input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ksel_if.sv =====
`default_nettype none

interface ksel_in_if;
  import ksel_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [BYTE_W-1:0] data_byte;
  logic              broadcast_flag;

  modport source (output valid, output mode, output data_byte, output broadcast_flag,
                  input ready);
  modport sink   (input valid, input mode, input data_byte, input broadcast_flag,
                  output ready);
endinterface

interface ksel_out_if;
  import ksel_pkg::*;

  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  shard_index;
  logic [HASH_W-1:0] key_hash;

  modport source (output valid, output shard_index, output key_hash, input ready);
  modport sink   (input valid, input shard_index, input key_hash, output ready);
endinterface

`default_nettype wire

// ===== rtl/ksel_ctrl.sv =====
`default_nettype none

module ksel_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic [ksel_pkg::MODE_W-1:0] in_mode_i,
  output logic                            in_ready_o,
  input  wire ksel_pkg::ctrl_sts_t        sts_i,
  output ksel_pkg::ctrl_cmd_t             cmd_o
);
  import ksel_pkg::*;

  state_e state_q, state_d;
  mode_e  mode;

  assign mode = mode_e'(in_mode_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        // hold a key end while the previous result is still pending
        in_ready_o = !(sts_i.out_valid && (mode == MODE_KEY_END));
        if (in_valid_i && in_ready_o) begin
          case (mode)
            MODE_FEED_BYTE, MODE_SYM_BYTE: cmd_o.mix = 1'b1;
            MODE_FEED_END: cmd_o.sep = 1'b1;
            MODE_KEY_END: begin
              cmd_o.key_end = 1'b1;
              if (!sts_i.bypass) begin
                state_d = ST_DIV;
              end
            end
            default: cmd_o = '0;
          endcase
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_div_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> !sts_i.out_valid)
    else $error("result pending during remainder computation");

  a_key_end_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.key_end && !sts_i.bypass) |=> (state_q == ST_DIV))
    else $error("key end did not start remainder computation");
`endif

endmodule

`default_nettype wire

// ===== rtl/ksel_dp.sv =====
`default_nettype none

module ksel_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ksel_pkg::cfg_t              cfg_i,
  input  wire logic [ksel_pkg::BYTE_W-1:0] data_byte_i,
  input  wire logic                        broadcast_flag_i,
  input  wire ksel_pkg::ctrl_cmd_t         cmd_i,
  output ksel_pkg::ctrl_sts_t              sts_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [ksel_pkg::CNT_W-1:0]       shard_index_o,
  output logic [ksel_pkg::HASH_W-1:0]      key_hash_o
);
  import ksel_pkg::*;

  logic [HASH_W-1:0] run_q, run_d;
  logic [HASH_W-1:0] feed_q, feed_d;
  logic [HASH_W-1:0] sep_hash;
  logic [HASH_W-1:0] sel_hash;
  logic              sel_bcast;
  logic              bypass;

  logic [HASH_W-1:0] dvd_q;
  logic [CNT_W-1:0]  div_q;
  logic [CNT_W-1:0]  rem_q;
  logic [STEP_W-1:0] step_q;
  logic              add_off_q;
  logic [CNT_W:0]    shifted;
  logic              fits;
  logic [CNT_W:0]    diff;
  logic [CNT_W-1:0]  rem_next;
  logic [CNT_W:0]    index_sum;
  logic              div_last;

  logic              out_valid_q;
  logic [CNT_W-1:0]  out_index_q;
  logic [HASH_W-1:0] out_hash_q;

  assign sep_hash  = fnv_mix(run_q, SEPARATOR);
  assign sel_bcast = (cfg_i.worker_total != '0) && broadcast_flag_i &&
                     (cfg_i.bcast_workers != '0);
  assign sel_hash  = sel_bcast ? feed_q : run_q;
  assign bypass    = (cfg_i.worker_total == '0) ||
                     (!sel_bcast && (cfg_i.shard_workers == '0));

  always_comb begin
    run_d  = run_q;
    feed_d = feed_q;
    if (cmd_i.mix) begin
      run_d = fnv_mix(run_q, data_byte_i);
    end else if (cmd_i.sep) begin
      run_d  = sep_hash;
      feed_d = sep_hash;
    end else if (cmd_i.key_end) begin
      run_d  = FNV_BASIS;
      feed_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= FNV_BASIS;
      feed_q <= '0;
    end else begin
      run_q  <= run_d;
      feed_q <= feed_d;
    end
  end

  // restoring remainder, one dividend bit per step
  assign shifted   = {rem_q, dvd_q[HASH_W-1]};
  assign fits      = shifted >= {1'b0, div_q};
  assign diff      = shifted - {1'b0, div_q};
  assign rem_next  = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
  assign div_last  = step_q == STEP_W'(HASH_W - 1);
  assign index_sum = {1'b0, rem_next} +
                     (add_off_q ? {{(CNT_W-OFF_W+1){1'b0}}, cfg_i.shard_offset} : '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_end) begin
      dvd_q     <= sel_hash;
      div_q     <= sel_bcast ? cfg_i.bcast_workers : cfg_i.shard_workers;
      rem_q     <= '0;
      step_q    <= '0;
      add_off_q <= !sel_bcast;
    end else if (cmd_i.div_step) begin
      dvd_q  <= dvd_q << 1;
      rem_q  <= rem_next;
      step_q <= step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_end) begin
      out_hash_q <= sel_hash;
    end
    if (cmd_i.key_end && bypass) begin
      out_index_q <= '0;
    end else if (cmd_i.div_step && div_last) begin
      out_index_q <= index_sum[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.key_end && bypass) || (cmd_i.div_step && div_last)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.bypass    = bypass;
  assign sts_o.div_last  = div_last;
  assign sts_o.out_valid = out_valid_q;

  assign out_valid_o   = out_valid_q;
  assign shard_index_o = out_index_q;
  assign key_hash_o    = out_hash_q;

`ifndef ASSERT_OFF
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < div_q))
    else $error("partial remainder not below divisor");

  a_key_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.key_end |=> ((run_q == FNV_BASIS) && (feed_q == '0)))
    else $error("hash state not cleared after key end");
`endif

endmodule

`default_nettype wire

// ===== rtl/keyed_shard_selector.sv =====
`default_nettype none

// Feed byte, symbol byte and end-of-feed transactions are accepted unless a
// remainder computation runs. End of key: result registered in the cycle after
// acceptance when a zero worker count applies, otherwise after 64 bit-serial
// remainder steps. A finished result waits in the output register while bytes
// keep flowing; the next end of key stalls until that result is taken.
// Asynchronous reset returns the hash state to the FNV offset basis and loads register defaults.
module keyed_shard_selector (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  ksel_in_if.sink                              in_i,
  ksel_out_if.source                           out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [ksel_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ksel_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ksel_pkg::*;

  cfg_t      cfg_q;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.worker_total  <= WORKER_TOTAL_RST;
      cfg_q.bcast_workers <= BCAST_WORKERS_RST;
      cfg_q.shard_workers <= SHARD_WORKERS_RST;
      cfg_q.shard_offset  <= SHARD_OFFSET_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WORKER_TOTAL:  cfg_q.worker_total  <= cfg_data_i[CNT_W-1:0];
        CFG_BCAST_WORKERS: cfg_q.bcast_workers <= cfg_data_i[CNT_W-1:0];
        CFG_SHARD_WORKERS: cfg_q.shard_workers <= cfg_data_i[CNT_W-1:0];
        CFG_SHARD_OFFSET:  cfg_q.shard_offset  <= cfg_data_i[OFF_W-1:0];
        default:           cfg_q <= cfg_q;
      endcase
    end
  end

  assign in_i.ready = in_ready;

  ksel_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ksel_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .data_byte_i      (in_i.data_byte),
    .broadcast_flag_i (in_i.broadcast_flag),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .shard_index_o    (out_o.shard_index),
    .key_hash_o       (out_o.key_hash)
  );

endmodule

`default_nettype wire

// ===== tb/ksel_route_checker.sv =====
`default_nettype none

module ksel_route_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  ksel_in_if                                   key_mon,
  ksel_out_if                                  shard_mon,
  input  wire logic                            cfg_we_i,
  input  wire logic [ksel_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ksel_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                          err_cnt_o,
  output int unsigned                          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ksel_pkg::*;

  localparam logic [HASH_W-1:0] FNV_PRIME_C = 64'd1099511628211;

  typedef struct packed {
    logic [CNT_W-1:0]  shard_index;
    logic [HASH_W-1:0] key_hash;
  } route_t;

  logic [CNT_W-1:0]  total_q;
  logic [CNT_W-1:0]  bcast_q;
  logic [CNT_W-1:0]  shard_q;
  logic [OFF_W-1:0]  offset_q;
  logic [HASH_W-1:0] run_hash;
  logic [HASH_W-1:0] feed_sig;
  route_t            routes_due[$];

  task automatic report(input string msg);
    $display("%0t: %s", $time, msg);
    err_cnt_o = err_cnt_o + 1;
  endtask

  function automatic logic [HASH_W-1:0] fold_byte(input logic [HASH_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
    return (h ^ HASH_W'(b)) * FNV_PRIME_C;
  endfunction

  function automatic route_t pick_route(input logic bcast);
    logic [HASH_W-1:0] h;
    logic [HASH_W-1:0] idx;
    h   = run_hash;
    idx = '0;
    if (total_q != '0) begin
      if (bcast && bcast_q != '0) begin
        h   = feed_sig;
        idx = h % HASH_W'(bcast_q);
      end else if (shard_q != '0) begin
        idx = HASH_W'(offset_q) + h % HASH_W'(shard_q);
      end
    end
    return '{shard_index: idx[CNT_W-1:0], key_hash: h};
  endfunction

  task automatic absorb(input mode_e m, input logic [BYTE_W-1:0] b, input logic bcast);
    case (m)
      MODE_FEED_BYTE, MODE_SYM_BYTE: begin
        run_hash = fold_byte(run_hash, b);
      end
      MODE_FEED_END: begin
        run_hash = fold_byte(run_hash, SEPARATOR);
        feed_sig = run_hash;
      end
      MODE_KEY_END: begin
        routes_due.push_back(pick_route(bcast));
        run_hash = FNV_BASIS;
        feed_sig = '0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic compare_route(input logic [CNT_W-1:0] idx, input logic [HASH_W-1:0] h);
    route_t want;
    if (routes_due.size() == 0) begin
      report($sformatf("unexpected result: shard_index %0d key_hash %h", idx, h));
    end else begin
      want = routes_due.pop_front();
      if (idx !== want.shard_index)
        report($sformatf("shard_index got %0d want %0d", idx, want.shard_index));
      if (h !== want.key_hash)
        report($sformatf("key_hash got %h want %h", h, want.key_hash));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   = WORKER_TOTAL_RST;
      bcast_q   = BCAST_WORKERS_RST;
      shard_q   = SHARD_WORKERS_RST;
      offset_q  = SHARD_OFFSET_RST;
      run_hash  = FNV_BASIS;
      feed_sig  = '0;
      routes_due.delete();
      err_cnt_o = 0;
      pending_o <= 0;
    end else begin
      if (shard_mon.valid && shard_mon.ready)
        compare_route(shard_mon.shard_index, shard_mon.key_hash);
      if (key_mon.valid && key_mon.ready)
        absorb(mode_e'(key_mon.mode), key_mon.data_byte, key_mon.broadcast_flag);
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_WORKER_TOTAL:  total_q  = cfg_data_i;
          CFG_BCAST_WORKERS: bcast_q  = cfg_data_i;
          CFG_SHARD_WORKERS: shard_q  = cfg_data_i;
          CFG_SHARD_OFFSET:  offset_q = cfg_data_i[OFF_W-1:0];
          default: begin
          end
        endcase
      end
      pending_o <= routes_due.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_keyed_shard_selector.sv =====
`default_nettype none

module tb_keyed_shard_selector;
  timeunit 1ns;
  timeprecision 1ps;

  import ksel_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned KEY_LATENCY    = 70;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  calm;
  int unsigned           err_cnt;
  int unsigned           pending;
  int unsigned           stall_cycles;
  int unsigned           txn_cnt;

  ksel_in_if  key_in ();
  ksel_out_if shard_out ();

  keyed_shard_selector dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (key_in),
    .out_o      (shard_out),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  ksel_route_checker u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_mon    (key_in),
    .shard_mon  (shard_out),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    shard_out.ready <= calm || ($urandom_range(99) >= 21);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (key_in.valid && key_in.ready) || (shard_out.valid && shard_out.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_txn(input mode_e m, input logic [BYTE_W-1:0] b, input logic f);
    while (!calm && $urandom_range(99) < 21) begin
      key_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    key_in.valid          <= 1'b1;
    key_in.mode           <= m;
    key_in.data_byte      <= b;
    key_in.broadcast_flag <= f;
    do @(posedge clk_i); while (!key_in.ready);
    txn_cnt++;
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] total, bcast, shard, offset);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_WORKER_TOTAL;
    cfg_data_i <= total;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_BCAST_WORKERS;
    cfg_data_i <= bcast;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SHARD_WORKERS;
    cfg_data_i <= shard;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SHARD_OFFSET;
    cfg_data_i <= offset;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // hold off until every outstanding route has come back and the block is quiet
  task automatic settle();
    key_in.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (KEY_LATENCY) @(posedge clk_i);
  endtask

  task automatic send_key();
    int unsigned n_feed;
    int unsigned n_sym;
    n_feed = $urandom_range(0, 8);
    n_sym  = $urandom_range(0, 8);
    repeat (n_feed)
      send_txn(MODE_FEED_BYTE, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
    send_txn(MODE_FEED_END, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
    repeat (n_sym)
      send_txn(MODE_SYM_BYTE, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
    send_txn(MODE_KEY_END, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic stream_keys(input int unsigned n);
    int unsigned start;
    start = txn_cnt;
    while (txn_cnt - start < n) begin
      if ($urandom_range(99) < 85) begin
        send_key();
      end else begin
        repeat ($urandom_range(1, 6))
          send_txn(mode_e'(MODE_W'($urandom_range(3))), BYTE_W'($urandom_range(255)),
                   1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] total;
    logic [CFG_DATA_W-1:0] bcast;
    logic [CFG_DATA_W-1:0] shard;
    logic [CFG_DATA_W-1:0] offset;

    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = CFG_WORKER_TOTAL;
    cfg_data_i            = '0;
    calm                  = 1'b0;
    txn_cnt               = 0;
    key_in.valid          = 1'b0;
    key_in.mode           = MODE_FEED_BYTE;
    key_in.data_byte      = '0;
    key_in.broadcast_flag = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    program_regs(11'd1024, 11'd7, 11'd13, 11'd1023);
    send_txn(MODE_FEED_BYTE, 8'h00, 1'b0);
    send_txn(MODE_FEED_BYTE, 8'hFF, 1'b1);
    send_txn(MODE_FEED_END,  8'hA5, 1'b0);
    send_txn(MODE_SYM_BYTE,  8'hAA, 1'b0);
    send_txn(MODE_SYM_BYTE,  8'h55, 1'b1);
    send_txn(MODE_KEY_END,   8'h00, 1'b0);
    // repeated end of feed, then broadcast
    send_txn(MODE_FEED_BYTE, 8'h12, 1'b0);
    send_txn(MODE_FEED_END,  8'h00, 1'b0);
    send_txn(MODE_FEED_END,  8'hFF, 1'b1);
    send_txn(MODE_SYM_BYTE,  8'h34, 1'b0);
    send_txn(MODE_KEY_END,   8'h00, 1'b1);
    // broadcast key with no end of feed
    send_txn(MODE_SYM_BYTE,  8'h80, 1'b0);
    send_txn(MODE_KEY_END,   8'hFF, 1'b1);
    send_txn(MODE_KEY_END,   8'h00, 1'b0);
    // symbol byte ahead of a feed byte
    send_txn(MODE_SYM_BYTE,  8'h01, 1'b0);
    send_txn(MODE_FEED_BYTE, 8'h7F, 1'b0);
    send_txn(MODE_FEED_END,  8'h00, 1'b0);
    send_txn(MODE_KEY_END,   8'h00, 1'b0);
    settle();

    program_regs(11'd0, 11'd5, 11'd9, 11'd100);
    stream_keys(60);
    settle();
    program_regs(11'd1024, 11'd0, 11'd1024, 11'd0);
    stream_keys(60);
    settle();
    program_regs(11'd1, 11'd1024, 11'd0, 11'd512);
    stream_keys(60);
    settle();
    program_regs(11'd2047, 11'd1, 11'd2047, 11'h7FF);
    stream_keys(60);
    settle();

    for (int p = 0; p < 6; p++) begin
      calm  <= (p == 2);
      total = ($urandom_range(9) == 0) ? 11'd0 : CFG_DATA_W'($urandom_range(1, 1024));
      bcast = ($urandom_range(3) == 0) ? 11'd0 : CFG_DATA_W'($urandom_range(1, 1024));
      shard = ($urandom_range(6) == 0) ? 11'd0 : CFG_DATA_W'($urandom_range(1, 1024));
      offset = CFG_DATA_W'($urandom_range(0, 1023));
      program_regs(total, bcast, shard, offset);
      stream_keys(100);
      settle();
    end
    calm <= 1'b0;
    settle();

    if (err_cnt == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
